@@ sv/sidbs_pkg.sv @@
// Shared types and constants for the sorted id binary search block.
// No dependencies; used by the controller, the datapath and the top level.
package sidbs_pkg;

   // Field types of the request and response beats
   typedef logic [11:0] slot_type;
   typedef logic [31:0] key_type;
   typedef logic [12:0] count_type;

   // Request command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic     command;
      slot_type slot;
      key_type  key;
   } req_payload_type;

   typedef struct packed {
      logic     found;
      slot_type match_slot;
   } rsp_payload_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic write_en;
      logic init;
      logic probe_first;
      logic probe_next;
      logic set_hit;
      logic set_miss;
      logic load_out;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic window_empty;
      logic key_eq;
      logic next_empty;
   } dp_status_type;

endpackage

@@ sv/sidbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sidbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sidbs_datapath.sv @@
// Datapath of the sorted id binary search: id table, search window, result.
// Depends on sidbs_pkg and sidbs_ram.
module sidbs_datapath #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sidbs_pkg::req_payload_type req_payload,
   input  logic                      csr_write_en,
   input  sidbs_pkg::count_type      csr_write_data,
   input  sidbs_pkg::ctl_cmd_type    cmd,
   output sidbs_pkg::dp_status_type  status,
   output sidbs_pkg::rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   sidbs_pkg::count_type       entry_count_ff;
   sidbs_pkg::key_type         key_ff;
   logic [CW-1:0]              lo_ff;
   logic [CW-1:0]              hi_ff;
   logic [CW-1:0]              lo_nx;
   logic [CW-1:0]              hi_nx;
   logic [CW-1:0]              hi_init;
   logic [AW-1:0]              mid_ff;
   logic [AW-1:0]              mid_cur;
   logic [AW-1:0]              mid_nx;
   logic [AW-1:0]              rd_addr;
   sidbs_pkg::key_type         rd_data;
   logic                       wr_in_range;
   logic                       key_lt;
   logic                       hit_ff;
   sidbs_pkg::slot_type        match_ff;
   sidbs_pkg::rsp_payload_type rsp_payload_ff;

   // Probe point of an inclusive window [lo, hi-1]
   function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
      logic [CW:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} - {{CW{1'b0}}, 1'b1};
      return AW'(sum >> 1);
   endfunction

   // Entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_en) begin
         entry_count_ff <= csr_write_data;
      end
   end

   // Clamp the count to the table depth
   always_comb begin
      if (32'(entry_count_ff) > 32'(TABLE_DEPTH)) begin
         hi_init = CW'(TABLE_DEPTH);
      end else begin
         hi_init = CW'(entry_count_ff);
      end
   end

   // Narrow the window from the entry just read
   assign key_lt  = key_ff < rd_data;
   assign lo_nx   = key_lt ? lo_ff : (CW'(mid_ff) + CW'(1));
   assign hi_nx   = key_lt ? CW'(mid_ff) : hi_ff;
   assign mid_cur = mid_of(lo_ff, hi_ff);
   assign mid_nx  = mid_of(lo_nx, hi_nx);
   assign rd_addr = cmd.probe_next ? mid_nx : mid_cur;

   assign status.window_empty = lo_ff >= hi_ff;
   assign status.key_eq       = rd_data == key_ff;
   assign status.next_empty   = lo_nx >= hi_nx;

   // Window and probe registers
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         lo_ff  <= '0;
         hi_ff  <= hi_init;
         key_ff <= req_payload.key;
      end else if (cmd.probe_next) begin
         lo_ff <= lo_nx;
         hi_ff <= hi_nx;
      end
      if (cmd.probe_first || cmd.probe_next) begin
         mid_ff <= rd_addr;
      end
   end

   // Id table
   assign wr_in_range = 32'(req_payload.slot) < 32'(TABLE_DEPTH);

   sidbs_ram #(
      .WIDTH ($bits(sidbs_pkg::key_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_en && wr_in_range),
      .wr_addr (AW'(req_payload.slot)),
      .wr_data (req_payload.key),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result and output beat registers
   always_ff @(posedge clock) begin
      if (cmd.set_hit) begin
         hit_ff   <= 1'b1;
         match_ff <= sidbs_pkg::slot_type'(mid_ff);
      end else if (cmd.set_miss) begin
         hit_ff   <= 1'b0;
         match_ff <= '0;
      end
      if (cmd.load_out) begin
         rsp_payload_ff.found      <= hit_ff;
         rsp_payload_ff.match_slot <= match_ff;
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule

@@ sv/sidbs_ctrl.sv @@
// Controller of the sorted id binary search: handshakes and search sequencing.
// Depends on sidbs_pkg.
module sidbs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_command,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  sidbs_pkg::dp_status_type status,
   output sidbs_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_STEP,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_command == sidbs_pkg::CMD_LOOKUP) begin
                  cmd.init = 1'b1;
                  state_in = ST_START;
               end else begin
                  cmd.write_en = 1'b1;
               end
            end
         end
         ST_START: begin
            if (status.window_empty) begin
               cmd.set_miss = 1'b1;
               state_in     = ST_FLUSH;
            end else begin
               cmd.probe_first = 1'b1;
               state_in        = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.key_eq) begin
               cmd.set_hit = 1'b1;
               state_in    = ST_FLUSH;
            end else if (status.next_empty) begin
               cmd.set_miss = 1'b1;
               state_in     = ST_FLUSH;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A lookup beat starts a search on the next cycle
   a_lookup_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_command == sidbs_pkg::CMD_LOOKUP |=> state_ff == ST_START)
      else $error("lookup beat did not start a search");

   // A response only appears out of the flush state
   a_rsp_from_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FLUSH)
      else $error("response raised outside flush");

   // Never overwrite a response the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("response overwritten while stalled");

   // A search step either narrows the window or ends the search
   a_step_exclusive: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.probe_next, cmd.set_hit, cmd.set_miss}) <= 1)
      else $error("conflicting search commands");

endmodule

@@ sv/sorted_id_binary_search.sv @@
// Sorted id binary search: table of ascending 32-bit ids with lookup by key.
// Depends on sidbs_pkg, sidbs_ctrl, sidbs_datapath (which holds sidbs_ram).
//
// Usage: the request channel carries write and lookup beats. A write beat
// stores key at slot (slots at or beyond TABLE_DEPTH are dropped) and gives
// no response. A lookup beat searches slots 0 to entry_count-1 (count
// clamped to TABLE_DEPTH) and gives one response beat with found and
// match_slot (zero on a miss). A lookup runs through a setup step, a probe
// step per probe and a flush step. Each probe is one read of the table RAM,
// so a table of n entries needs at most floor(log2 n)+1 probes: 13 for 4096.
// The request channel stalls for the whole search and takes the next beat
// the cycle after the response is loaded. The response sits in an output
// register, so a new beat is taken while it waits; a further lookup then
// holds in its flush state until the receiver stops stalling. The user must
// write entry_count through the csr port only while idle; the block itself
// does not enforce this. Reset clears entry_count and all control state;
// the table is not cleared, and its entries must be written before they
// are searched.
module sorted_id_binary_search #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sidbs_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sidbs_pkg::rsp_payload_type rsp_payload,
   input  logic                       csr_write_en,
   input  sidbs_pkg::count_type       csr_write_data
);

   sidbs_pkg::ctl_cmd_type   cmd;
   sidbs_pkg::dp_status_type status;

   // Sequence the search
   sidbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Hold the table, window and result
   sidbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_payload    (rsp_payload)
   );

endmodule
